FILE: hdl/rfc_pkg.sv
// rfc_pkg: shared constants, codes and item types for the response frame checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rfc_pkg;

  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned STORE_LEN   = FRAME_BYTES + 1;
  localparam int unsigned ADDR_W      = $clog2(STORE_LEN);
  localparam int unsigned CNT_W       = $clog2(STORE_LEN + 1);
  localparam int unsigned CMP_W       = ((CNT_W > 8) ? CNT_W : 8) + 2;

  // Frame layout, in store positions (status byte at position 0)
  localparam int unsigned HDR_BYTES   = 7;
  localparam int unsigned HDR_IDX_W   = $clog2(HDR_BYTES);
  localparam int unsigned SUM_FIRST   = 6;
  localparam int unsigned BODY_START  = 8;
  localparam int unsigned MIN_READ    = 8;
  localparam int unsigned MIN_LEN     = 2;

  localparam logic [7:0] PREAMBLE_LO = 8'h00;
  localparam logic [7:0] PREAMBLE_HI = 8'hFF;
  localparam logic [7:0] APP_ERR_LEN = 8'h01;
  localparam logic [7:0] APP_ERR_LCS = 8'hFF;
  localparam logic [7:0] APP_ERR_TFI = 8'h7F;
  localparam logic [7:0] FRAME_ID    = 8'hD5;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_COMMAND = 1'b0,
    REG_BODY_CAPACITY    = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OUT_OK        = 4'd0,
    OUT_SHORT     = 4'd1,
    OUT_PREAMBLE  = 4'd2,
    OUT_APP_ERROR = 4'd3,
    OUT_LEN_CSUM  = 4'd4,
    OUT_TRUNCATED = 4'd5,
    OUT_DATA_CSUM = 4'd6,
    OUT_ID_ECHO   = 4'd7,
    OUT_OVERFLOW  = 4'd8
  } outcome_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_read;
  } in_item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       has_data;
    logic [3:0] outcome;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [7:0] expected_command;
    logic [6:0] body_capacity;
  } cfg_t;

  typedef struct packed {
    outcome_e   outcome;
    logic [7:0] payload_len;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

FILE: hdl/response_frame_checker.sv
// response_frame_checker: top level; configuration registers and busy logic.
// Instantiates rfc_front, rfc_queue and rfc_back; depends on rfc_pkg.
`timescale 1ns / 1ps
//
// Usage
//   Input: one byte of a read transaction per item, the status byte first,
//   end_of_read set on the final byte. An item is taken on an edge where
//   start is high and busy is low. Bytes of one transaction may arrive in
//   consecutive cycles; only the first FRAME_BYTES+1 are stored.
//   Results: res_valid_o marks each result item for exactly one cycle; the
//   receiver cannot stall, so every strobed item must be taken.
//   After the final byte the registered end flag starts classification, the
//   job passes through the job queue, and the result item is registered
//   before it is strobed; a body byte also passes the registered store read.
//   A failed or empty-body frame gives one item; a good frame gives its body
//   bytes at one per cycle, limited by the single read port of the frame store.
//   busy stays high from the final byte until the job is taken and, for a
//   good frame, until its last body byte has been read from the store.
//   Configuration: cfg_valid_i/cfg_ready_o write channel, always ready;
//   index 0 expected command, index 1 body capacity. Write only while idle.
//   Reset: asynchronous, active low; clears byte count, queue, back state and
//   the registers to expected command 0 and capacity 64. The frame store is
//   not cleared: only entries written in the current transaction are read.

module response_frame_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  rfc_pkg::in_item_t                  item_i,
  output logic                               res_valid_o,
  output rfc_pkg::res_item_t                 res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [7:0]                         cfg_data_i
);
  import rfc_pkg::*;

  cfg_t    cfg_q;
  logic    accept;
  mem_wr_t mem_wr;
  logic    job_push;
  job_t    job_in;
  logic    job_pop;
  logic    job_valid;
  job_t    job_out;
  logic    front_pending;
  logic    back_active;

  // config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_command <= 8'd0;
      cfg_q.body_capacity    <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EXPECTED_COMMAND: cfg_q.expected_command <= cfg_data_i;
        REG_BODY_CAPACITY:    cfg_q.body_capacity    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // busy covers classification, a queued job and body emission
  assign busy   = front_pending || job_valid || back_active;
  assign accept = start && !busy;

  rfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cfg_i      (cfg_q),
    .mem_wr_o   (mem_wr),
    .job_push_o (job_push),
    .job_o      (job_in),
    .pending_o  (front_pending)
  );

  rfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .job_i       (job_in),
    .pop_i       (job_pop),
    .not_empty_o (job_valid),
    .job_o       (job_out)
  );

  rfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_wr_i    (mem_wr),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .active_o    (back_active),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

FILE: hdl/rfc_front.sv
// rfc_front: takes bytes, writes the frame store, keeps header bytes and the
// running data checksum, and classifies the frame in the cycle after the end flag is taken.
// Depends on rfc_pkg.
`timescale 1ns / 1ps

module rfc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  rfc_pkg::in_item_t item_i,
  input  rfc_pkg::cfg_t    cfg_i,
  output rfc_pkg::mem_wr_t mem_wr_o,
  output logic             job_push_o,
  output rfc_pkg::job_t    job_o,
  output logic             pending_o
);
  import rfc_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_q;
  logic             pend_q;
  logic [7:0]       hdr_q [HDR_BYTES];
  logic [7:0]       sum_q;
  logic             store_ok;
  logic             hdr_hit;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [CMP_W-1:0] rel;
  logic             sum_hit;
  logic [CNT_W-1:0] n_new;

  assign store_ok = cnt_q < CNT_W'(STORE_LEN);
  assign n_new    = store_ok ? cnt_q + CNT_W'(1) : cnt_q;
  assign hdr_hit  = (cnt_q >= CNT_W'(1)) && (cnt_q <= CNT_W'(HDR_BYTES));
  assign hdr_idx  = HDR_IDX_W'(cnt_q - CNT_W'(1));
  assign rel      = CMP_W'(cnt_q) - CMP_W'(SUM_FIRST);
  // checksum window: TFI up to and including DCS, LEN known by then
  assign sum_hit  = (cnt_q >= CNT_W'(SUM_FIRST)) && store_ok &&
                    (rel <= CMP_W'(hdr_q[3]));

  assign mem_wr_o.en   = accept_i && store_ok;
  assign mem_wr_o.addr = ADDR_W'(cnt_q);
  assign mem_wr_o.data = item_i.rx_byte;

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      if (item_i.end_of_read) begin
        cnt_d = '0;
      end else begin
        cnt_d = n_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      n_q    <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= accept_i && item_i.end_of_read;
      if (accept_i && item_i.end_of_read) begin
        n_q <= n_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && hdr_hit) begin
      hdr_q[hdr_idx] <= item_i.rx_byte;
    end
    if (accept_i) begin
      if (cnt_q == '0) begin
        sum_q <= '0;
      end else if (sum_hit) begin
        sum_q <= sum_q + item_i.rx_byte;
      end
    end
  end

  // classification, in fixed priority
  logic [7:0]       len;
  logic [7:0]       lcs_sum;
  logic [7:0]       rsp_exp;
  logic [7:0]       payload_len;
  outcome_e         code;

  assign len         = hdr_q[3];
  assign lcs_sum     = hdr_q[3] + hdr_q[4];
  assign rsp_exp     = cfg_i.expected_command + 8'd1;
  assign payload_len = len - 8'(MIN_LEN);

  always_comb begin
    priority if (n_q < CNT_W'(MIN_READ)) begin
      code = OUT_SHORT;
    end else if (hdr_q[0] != PREAMBLE_LO || hdr_q[1] != PREAMBLE_LO ||
                 hdr_q[2] != PREAMBLE_HI) begin
      code = OUT_PREAMBLE;
    end else if (hdr_q[3] == APP_ERR_LEN && hdr_q[4] == APP_ERR_LCS &&
                 hdr_q[5] == APP_ERR_TFI) begin
      code = OUT_APP_ERROR;
    end else if (lcs_sum != 8'd0 || len < 8'(MIN_LEN)) begin
      code = OUT_LEN_CSUM;
    end else if (CMP_W'(len) + CMP_W'(MIN_READ) > CMP_W'(n_q)) begin
      code = OUT_TRUNCATED;
    end else if (sum_q != 8'd0) begin
      code = OUT_DATA_CSUM;
    end else if (hdr_q[5] != FRAME_ID || hdr_q[6] != rsp_exp) begin
      code = OUT_ID_ECHO;
    end else if (payload_len > {1'b0, cfg_i.body_capacity}) begin
      code = OUT_OVERFLOW;
    end else begin
      code = OUT_OK;
    end
  end

  assign job_push_o        = pend_q;
  assign job_o.outcome     = code;
  assign job_o.payload_len = payload_len;
  assign pending_o         = pend_q;

endmodule

FILE: hdl/rfc_queue.sv
// rfc_queue: short job queue between the classifying front and the emitting back.
// Depends on rfc_pkg.
`timescale 1ns / 1ps

module rfc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rfc_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          not_empty_o,
  output rfc_pkg::job_t job_o
);
  import rfc_pkg::*;

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_q, tail_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              full;

  assign not_empty_o = cnt_q != '0;
  assign full        = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign job_o       = slot_q[head_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[tail_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        tail_q <= (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QPTR_W'(1);
      end
      if (pop_i) begin
        head_q <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full || pop_i) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o) else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("job queue count out of range");
`endif

endmodule

FILE: hdl/rfc_back.sv
// rfc_back: owns the frame store, takes jobs from the queue and emits either a single
// outcome item or the body bytes, one per cycle. Depends on rfc_pkg.
`timescale 1ns / 1ps

module rfc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfc_pkg::mem_wr_t   mem_wr_i,
  input  logic               job_valid_i,
  input  rfc_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               active_o,
  output logic               res_valid_o,
  output rfc_pkg::res_item_t res_o
);
  import rfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [7:0]        mem_q [STORE_LEN];
  logic [7:0]        rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        idx_q, idx_d;
  logic [7:0]        blen_q, blen_d;
  logic              strobe_q, strobe_d;
  logic              has_q, has_d;
  logic              last_q, last_d;
  outcome_e          outcome_q, outcome_d;
  logic              final_byte;

  assign rd_addr    = ADDR_W'(CMP_W'(BODY_START) + CMP_W'(idx_q));
  assign final_byte = idx_q == blen_q - 8'd1;

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign active_o  = state_q == ST_RUN;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    blen_d    = blen_q;
    strobe_d  = 1'b0;
    has_d     = 1'b0;
    last_d    = 1'b0;
    outcome_d = OUT_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          if (job_i.outcome != OUT_OK || job_i.payload_len == 8'd0) begin
            strobe_d  = 1'b1;
            last_d    = 1'b1;
            outcome_d = job_i.outcome;
          end else begin
            state_d = ST_RUN;
            idx_d   = 8'd0;
            blen_d  = job_i.payload_len;
          end
        end
      end
      ST_RUN: begin
        strobe_d = 1'b1;
        has_d    = 1'b1;
        last_d   = final_byte;
        idx_d    = idx_q + 8'd1;
        if (final_byte) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      blen_q    <= '0;
      strobe_q  <= 1'b0;
      has_q     <= 1'b0;
      last_q    <= 1'b0;
      outcome_q <= OUT_OK;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      blen_q    <= blen_d;
      strobe_q  <= strobe_d;
      has_q     <= has_d;
      last_q    <= last_d;
      outcome_q <= outcome_d;
    end
  end

  assign res_valid_o     = strobe_q;
  assign res_o.body_byte = has_q ? rd_q : 8'd0;
  assign res_o.has_data  = has_q;
  assign res_o.outcome   = outcome_q;
  assign res_o.last      = last_q;

`ifndef NO_ASSERTIONS
  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.has_data |-> res_o.last && res_o.body_byte == 8'd0)
    else $error("dataless item must be the last one");
  a_data_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.has_data |-> res_o.outcome == OUT_OK)
    else $error("body byte carries an error code");
  a_run_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> !job_pop_o) else $error("job taken while emitting");
  a_run_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |=> res_valid_o && res_o.has_data)
    else $error("body emission gap");
`endif

endmodule
